FILE: rtl/afr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_pkg
// Shared widths and pipeline payload types for the aspect-fit rectangle unit.
// ----------------------------------------------------------------------------
package afr_pkg;

   localparam int DIM_BITS   = 16;
   localparam int OFS_BITS   = DIM_BITS - 1;
   localparam int PROD_BITS  = 2 * DIM_BITS;
   localparam int DIV_STAGES = DIM_BITS;

   typedef logic [DIM_BITS-1:0]  dim_type;
   typedef logic [OFS_BITS-1:0]  ofs_type;
   typedef logic [PROD_BITS-1:0] prod_type;

   // Per-request sideband that rides along the divider stages.
   typedef struct packed {
      logic    valid;
      logic    zero;    // some input dimension was zero
      logic    wide;    // source relatively wider: width follows destination
      dim_type dst_w;
      dim_type dst_h;
   } side_type;

   // Divider stage payload: partial remainder, dividend bits still to
   // shift in (low end fills with quotient bits), and the divisor.
   typedef struct packed {
      side_type side;
      dim_type  rem;
      dim_type  low;
      dim_type  divisor;
   } div_type;

endpackage

FILE: rtl/afr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_front
// Cross products, aspect compare and divide operand select (two stages).
// ----------------------------------------------------------------------------
module afr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             req_valid,
   input  afr_pkg::dim_type src_width,
   input  afr_pkg::dim_type src_height,
   input  afr_pkg::dim_type dst_width,
   input  afr_pkg::dim_type dst_height,
   output afr_pkg::div_type div_out
);

   // stage A: products
   logic              a_valid_ff;
   logic              a_zero_ff,  a_zero_in;
   afr_pkg::prod_type a_wh_ff,    a_wh_in;     // src_width * dst_height
   afr_pkg::prod_type a_hw_ff,    a_hw_in;     // src_height * dst_width
   afr_pkg::dim_type  a_sw_ff,    a_sh_ff;
   afr_pkg::dim_type  a_dw_ff,    a_dh_ff;

   // stage B: selected division
   logic              b_valid_ff;
   afr_pkg::div_type  b_ff,       b_in;
   logic              wide;
   afr_pkg::prod_type dividend;

   assign a_zero_in = (src_width == '0) || (src_height == '0) ||
                      (dst_width == '0) || (dst_height == '0);
   assign a_wh_in   = afr_pkg::prod_type'(src_width)  * afr_pkg::prod_type'(dst_height);
   assign a_hw_in   = afr_pkg::prod_type'(src_height) * afr_pkg::prod_type'(dst_width);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_zero_ff <= a_zero_in;
         a_wh_ff   <= a_wh_in;
         a_hw_ff   <= a_hw_in;
         a_sw_ff   <= src_width;
         a_sh_ff   <= src_height;
         a_dw_ff   <= dst_width;
         a_dh_ff   <= dst_height;
         b_ff      <= b_in;
      end
   end

   // Equal aspect counts as wider.
   assign wide     = (a_wh_ff >= a_hw_ff);
   assign dividend = wide ? a_hw_ff : a_wh_ff;

   always_comb begin
      b_in              = '0;
      b_in.side.valid   = a_valid_ff;
      b_in.side.zero    = a_zero_ff;
      b_in.side.wide    = wide;
      b_in.side.dst_w   = a_dw_ff;
      b_in.side.dst_h   = a_dh_ff;
      b_in.rem          = dividend[afr_pkg::PROD_BITS-1:afr_pkg::DIM_BITS];
      b_in.low          = dividend[afr_pkg::DIM_BITS-1:0];
      b_in.divisor      = wide ? a_sw_ff : a_sh_ff;
   end

   always_comb begin
      div_out            = b_ff;
      div_out.side.valid = b_valid_ff;
   end

endmodule

FILE: rtl/afr_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_div_stage
// One restoring-division step: resolves one quotient bit per stage.
// ----------------------------------------------------------------------------
module afr_div_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  afr_pkg::div_type div_in,
   output afr_pkg::div_type div_out
);

   logic                        valid_ff;
   afr_pkg::div_type            stage_ff, stage_in;
   logic [afr_pkg::DIM_BITS:0]  trial;
   logic [afr_pkg::DIM_BITS:0]  diff;
   logic                        q_bit;

   // Shift the next dividend bit into the remainder and try the subtract.
   assign trial = {div_in.rem, div_in.low[afr_pkg::DIM_BITS-1]};
   assign diff  = trial - {1'b0, div_in.divisor};
   assign q_bit = (trial >= {1'b0, div_in.divisor});

   always_comb begin
      stage_in     = div_in;
      stage_in.rem = q_bit ? diff[afr_pkg::DIM_BITS-1:0] : trial[afr_pkg::DIM_BITS-1:0];
      stage_in.low = {div_in.low[afr_pkg::DIM_BITS-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= div_in.side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   always_comb begin
      div_out            = stage_ff;
      div_out.side.valid = valid_ff;
   end

endmodule

FILE: rtl/afr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afr_back
// Clamp of the scaled size, centering offsets and the response register.
// ----------------------------------------------------------------------------
module afr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  afr_pkg::div_type div_in,
   output logic             rsp_valid,
   output afr_pkg::ofs_type rsp_fit_x,
   output afr_pkg::ofs_type rsp_fit_y,
   output afr_pkg::dim_type rsp_fit_width,
   output afr_pkg::dim_type rsp_fit_height
);

   logic             valid_ff;
   afr_pkg::ofs_type x_ff, x_in;
   afr_pkg::ofs_type y_ff, y_in;
   afr_pkg::dim_type w_ff, w_in;
   afr_pkg::dim_type h_ff, h_in;
   afr_pkg::dim_type scaled;
   afr_pkg::dim_type fw, fh;
   afr_pkg::dim_type spare_w, spare_h;

   // Never let the scaled side collapse to nothing.
   assign scaled = (div_in.low == '0) ? afr_pkg::dim_type'(1) : div_in.low;
   assign fw     = div_in.side.wide ? div_in.side.dst_w : scaled;
   assign fh     = div_in.side.wide ? scaled : div_in.side.dst_h;
   assign spare_w = div_in.side.dst_w - fw;
   assign spare_h = div_in.side.dst_h - fh;

   always_comb begin
      if (div_in.side.zero) begin
         x_in = '0;
         y_in = '0;
         w_in = '0;
         h_in = '0;
      end else begin
         x_in = spare_w[afr_pkg::DIM_BITS-1:1];
         y_in = spare_h[afr_pkg::DIM_BITS-1:1];
         w_in = fw;
         h_in = fh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= div_in.side.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         w_ff <= w_in;
         h_ff <= h_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_fit_x      = x_ff;
   assign rsp_fit_y      = y_ff;
   assign rsp_fit_width  = w_ff;
   assign rsp_fit_height = h_ff;

endmodule

FILE: rtl/aspect_fit_rectangle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspect_fit_rectangle_unit
// Letterbox fit: centered source-shaped rectangle inside a destination area.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries a source size and a
//   destination size. Response channel (rsp_valid/rsp_ready) returns the
//   fitted rectangle: offsets fit_x/fit_y and size fit_width/fit_height.
//   Every request gives exactly one response, in order.
//   The pipeline is 19 register stages: two front stages (cross products,
//   then aspect compare and operand select), 16 divider stages resolving
//   one quotient bit each, and the output register.
//   Throughput is one request per cycle; nothing loops back, so the
//   pipeline takes a new request every cycle while rsp_ready stays high.
//   When the receiver stalls with a response waiting, the whole pipeline
//   holds in place and req_ready drops in the same cycle; nothing is
//   dropped or repeated. Reset clears all stage valid bits; the block is
//   ready on the first cycle after reset.
//   Any zero dimension yields an all-zero response.
// ----------------------------------------------------------------------------
module aspect_fit_rectangle_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  afr_pkg::dim_type req_src_width,
   input  afr_pkg::dim_type req_src_height,
   input  afr_pkg::dim_type req_dst_width,
   input  afr_pkg::dim_type req_dst_height,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output afr_pkg::ofs_type rsp_fit_x,
   output afr_pkg::ofs_type rsp_fit_y,
   output afr_pkg::dim_type rsp_fit_width,
   output afr_pkg::dim_type rsp_fit_height
);

   // Advance every stage unless a finished response is waiting and rsp_ready is low.
   logic             en;
   afr_pkg::div_type div_chain [0:afr_pkg::DIV_STAGES];

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Front: products and selection of dividend/divisor.
   afr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .req_valid  (req_valid),
      .src_width  (req_src_width),
      .src_height (req_src_height),
      .dst_width  (req_dst_width),
      .dst_height (req_dst_height),
      .div_out    (div_chain[0])
   );

   // Divider: one quotient bit per stage, MSB first.
   for (genvar i = 0; i < afr_pkg::DIV_STAGES; i++) begin : g_div
      afr_div_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .div_in  (div_chain[i]),
         .div_out (div_chain[i+1])
      );
   end

   // Back: clamp, offsets, response register.
   afr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .div_in         (div_chain[afr_pkg::DIV_STAGES]),
      .rsp_valid      (rsp_valid),
      .rsp_fit_x      (rsp_fit_x),
      .rsp_fit_y      (rsp_fit_y),
      .rsp_fit_width  (rsp_fit_width),
      .rsp_fit_height (rsp_fit_height)
   );

   // A stalled response must freeze the front of the pipe too.
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while response stalled");

   // An empty width means the all-zero case: everything else is zero too.
   a_zero_all: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fit_width == '0) |->
         (rsp_fit_height == '0 && rsp_fit_x == '0 && rsp_fit_y == '0))
      else $error("partial zero response");

   // Outside the zero case the height is never clamped to nothing.
   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fit_width != '0) |-> (rsp_fit_height != '0))
      else $error("fitted height empty with nonzero width");

   // A valid bit can only reach the output after the front saw a request.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (en && !div_chain[afr_pkg::DIV_STAGES].side.valid) |=> !rsp_valid)
      else $error("response appeared without a request in flight");

endmodule
